[rtl/wpsp_pkg.sv]
// Shared types and constants for the world point to screen projection pipeline.
package wpsp_pkg;

  localparam int WC_W   = 24;   // world coordinate, Q12.12
  localparam int ENT_W  = 16;   // view matrix entry, Q2.14
  localparam int ROW_W  = 48;
  localparam int PRD_W  = 40;   // world * entry
  localparam int SUM_W  = 42;   // view sum, 26 fraction bits
  localparam int V_W    = 27;   // view coordinate, Q.12, and its magnitude
  localparam int SC_W   = 24;   // projection scale
  localparam int SCH_W  = 12;   // scale half for partial products
  localparam int PP_W   = V_W + SCH_W;
  localparam int M_W    = V_W + SC_W;
  localparam int NUM_W  = M_W + 8;          // numerator magnitude
  localparam int QW     = 45;               // quotient bits kept
  localparam int QB_W   = 6;
  localparam int HI_W   = NUM_W - QW;       // numerator bits above the quotient
  localparam int NDC_W  = QW + 1;
  localparam int VP_W   = 16;
  localparam int AL_W   = 23;               // low split of the offset ndc
  localparam int AH_W   = NDC_W - AL_W;
  localparam int PL_W   = AL_W + VP_W;
  localparam int PH_W   = AH_W + VP_W + 1;
  localparam int PF_W   = NDC_W + VP_W + 1;
  localparam int SH_W   = PF_W - 13;
  localparam int SCR_W  = 32;
  localparam int CFG_W  = 48;
  localparam int CIDX_W = 3;

  localparam logic [QW-1:0]            NDC_LIM  = QW'(1) << 44;
  localparam logic signed [NDC_W-1:0]  NDC_ONE  = NDC_W'(1) << 20;
  localparam logic signed [SCR_W-1:0]  SENTINEL = -32'sd2560000;
  localparam logic signed [SH_W-1:0]   SAT_MAX  = SH_W'(64'sd2147483647);
  localparam logic signed [SH_W-1:0]   SAT_MIN  = SH_W'(-64'sd2147483648);
  localparam logic [31:0]              VP_RESET = 32'd52429400;

  typedef enum logic [CIDX_W-1:0] {
    REG_VIEW_ROW_X = 3'd0,
    REG_VIEW_ROW_Y = 3'd1,
    REG_VIEW_ROW_Z = 3'd2,
    REG_TRANS_X    = 3'd3,
    REG_TRANS_Y    = 3'd4,
    REG_TRANS_Z    = 3'd5,
    REG_PROJ_SCALE = 3'd6,
    REG_VIEWPORT   = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [ROW_W-1:0]        row_x;
    logic [ROW_W-1:0]        row_y;
    logic [ROW_W-1:0]        row_z;
    logic signed [WC_W-1:0]  trans_x;
    logic signed [WC_W-1:0]  trans_y;
    logic signed [WC_W-1:0]  trans_z;
    logic [SC_W-1:0]         scale_x;
    logic [SC_W-1:0]         scale_y;
    logic [VP_W-1:0]         vp_w;
    logic [VP_W-1:0]         vp_h;
  } cfg_t;

  typedef struct packed {
    logic [V_W-1:0] mag_x;
    logic [V_W-1:0] mag_y;
    logic           neg_x;
    logic           neg_y;
    logic [V_W-1:0] d;
    logic           behind;
  } view_t;

  typedef struct packed {
    logic [NUM_W-1:0] num_x;
    logic [NUM_W-1:0] num_y;
    logic             neg_x;
    logic             neg_y;
    logic [V_W-1:0]   d;
    logic             behind;
  } num_t;

  typedef struct packed {
    logic [V_W-1:0] rem_x;
    logic [V_W-1:0] rem_y;
    logic [QW-1:0]  lo_x;
    logic [QW-1:0]  lo_y;
    logic [QW-1:0]  q_x;
    logic [QW-1:0]  q_y;
    logic           ovf_x;
    logic           ovf_y;
    logic           neg_x;
    logic           neg_y;
    logic [V_W-1:0] d;
    logic           behind;
  } div_st_t;

  typedef struct packed {
    logic signed [SCR_W-1:0] sx;
    logic signed [SCR_W-1:0] sy;
    logic                    behind;
  } scr_t;

endpackage

[rtl/world_point_screen_projection_core.sv]
// Top level: config registers, projection pipeline and output register with skid.
//
//  channel | ports                                      | accepted when
//  --------+--------------------------------------------+-----------------------
//  input   | in_valid in_stall in_world_x/y/z           | in_valid & !in_stall
//  result  | out_valid out_stall out_screen_x/y out_behind | out_valid & !out_stall
//  config  | cfg_we cfg_index cfg_wdata                 | cfg_we
//
// One beat per cycle sustained while in_stall is low. An accepted beat reaches out_valid
// through 54 register stages: 2 view, 2 scale, 46 divider (overflow check, then one
// quotient bit per stage), 3 viewport and the output register.
// Reset clears all valid bits; config resets to zero, viewport to 800 x 600.
// While the output beat is stalled, the next pipeline beat parks in a one-entry skid;
// in_stall rises only while it is full, and the whole pipeline holds in that cycle.
module world_point_screen_projection_core (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [wpsp_pkg::WC_W-1:0]   in_world_x,
  input  logic signed [wpsp_pkg::WC_W-1:0]   in_world_y,
  input  logic signed [wpsp_pkg::WC_W-1:0]   in_world_z,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [wpsp_pkg::SCR_W-1:0]  out_screen_x,
  output logic signed [wpsp_pkg::SCR_W-1:0]  out_screen_y,
  output logic                               out_behind,
  input  logic                               cfg_we,
  input  logic [wpsp_pkg::CIDX_W-1:0]        cfg_index,
  input  logic [wpsp_pkg::CFG_W-1:0]         cfg_wdata
);
  import wpsp_pkg::*;

  cfg_t    cfg_r;
  logic    en, in_ok;
  logic    vv, sv, dv, pv;
  view_t   view;
  num_t    num;
  div_st_t quo;
  scr_t    scr;
  scr_t    out_r, skid_r;
  logic    out_v_r, skid_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{vp_w: VP_RESET[31:16], vp_h: VP_RESET[15:0], default: '0};
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_VIEW_ROW_X: cfg_r.row_x   <= cfg_wdata;
        REG_VIEW_ROW_Y: cfg_r.row_y   <= cfg_wdata;
        REG_VIEW_ROW_Z: cfg_r.row_z   <= cfg_wdata;
        REG_TRANS_X:    cfg_r.trans_x <= cfg_wdata[WC_W-1:0];
        REG_TRANS_Y:    cfg_r.trans_y <= cfg_wdata[WC_W-1:0];
        REG_TRANS_Z:    cfg_r.trans_z <= cfg_wdata[WC_W-1:0];
        REG_PROJ_SCALE: begin
          cfg_r.scale_x <= cfg_wdata[SC_W-1:0];
          cfg_r.scale_y <= cfg_wdata[2*SC_W-1:SC_W];
        end
        REG_VIEWPORT: begin
          cfg_r.vp_w <= cfg_wdata[31:16];
          cfg_r.vp_h <= cfg_wdata[15:0];
        end
        default: ;
      endcase
    end
  end

  assign en       = !skid_v_r;
  assign in_stall = skid_v_r;
  assign in_ok    = in_valid && !skid_v_r;

  wpsp_view u_view (
    .clk(clk), .rst_n(rst_n), .en(en), .in_ok(in_ok),
    .wx(in_world_x), .wy(in_world_y), .wz(in_world_z), .cfg(cfg_r),
    .vld(vv), .view(view)
  );

  wpsp_scale u_scale (
    .clk(clk), .rst_n(rst_n), .en(en), .in_vld(vv), .view(view), .cfg(cfg_r),
    .vld(sv), .num(num)
  );

  wpsp_div u_div (
    .clk(clk), .rst_n(rst_n), .en(en), .in_vld(sv), .num(num),
    .vld(dv), .q(quo)
  );

  wpsp_vp u_vp (
    .clk(clk), .rst_n(rst_n), .en(en), .in_vld(dv), .q(quo), .cfg(cfg_r),
    .vld(pv), .scr(scr)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      if (!out_stall) begin
        skid_v_r <= 1'b0;
      end
    end else if (out_v_r && out_stall) begin
      skid_v_r <= pv;
    end else begin
      out_v_r <= pv;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v_r) begin
      if (!out_stall) begin
        out_r <= skid_r;
      end
    end else if (out_v_r && out_stall) begin
      skid_r <= scr;
    end else begin
      out_r <= scr;
    end
  end

  assign out_valid    = out_v_r;
  assign out_screen_x = out_r.sx;
  assign out_screen_y = out_r.sy;
  assign out_behind   = out_r.behind;

  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid holds a beat with no output beat");

  a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_v_r) |-> $past(out_v_r && out_stall && pv))
    else $error("skid filled without a stalled output");

  a_out_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_stall |=> out_v_r && $stable(out_r))
    else $error("stalled output beat changed");

  a_sentinel: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_r.behind |-> out_r.sx == SENTINEL && out_r.sy == SENTINEL)
    else $error("behind beat without sentinel");

endmodule

[rtl/wpsp_view.sv]
// View transform: matrix products, then sums floored to Q.12 with front/behind split.
module wpsp_view (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_ok,
  input  logic signed [wpsp_pkg::WC_W-1:0] wx,
  input  logic signed [wpsp_pkg::WC_W-1:0] wy,
  input  logic signed [wpsp_pkg::WC_W-1:0] wz,
  input  wpsp_pkg::cfg_t                cfg,
  output logic                          vld,
  output wpsp_pkg::view_t               view
);
  import wpsp_pkg::*;

  logic signed [PRD_W-1:0] prd_r [3][3];
  logic signed [PRD_W-1:0] prd_nxt [3][3];
  logic signed [WC_W+13:0] tr_r [3];
  logic                    v1_r, v2_r;
  view_t                   view_r, view_nxt;
  logic signed [SUM_W-1:0] sum [3];
  logic signed [V_W-1:0]   v12 [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      prd_nxt[0][k] = wx * $signed(cfg.row_x[ENT_W*k +: ENT_W]);
      prd_nxt[1][k] = wy * $signed(cfg.row_y[ENT_W*k +: ENT_W]);
      prd_nxt[2][k] = wz * $signed(cfg.row_z[ENT_W*k +: ENT_W]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_ok;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prd_r  <= prd_nxt;
      tr_r[0] <= {cfg.trans_x, 14'd0};
      tr_r[1] <= {cfg.trans_y, 14'd0};
      tr_r[2] <= {cfg.trans_z, 14'd0};
      view_r <= view_nxt;
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sum[k] = SUM_W'(prd_r[0][k]) + SUM_W'(prd_r[1][k]) + SUM_W'(prd_r[2][k])
             + SUM_W'(tr_r[k]);
      // dropping 14 bits of a two's complement sum floors it
      v12[k] = sum[k][V_W+13:14];
    end
    view_nxt.neg_x  = v12[0][V_W-1];
    view_nxt.neg_y  = v12[1][V_W-1];
    view_nxt.mag_x  = v12[0][V_W-1] ? V_W'(-v12[0]) : V_W'(v12[0]);
    view_nxt.mag_y  = v12[1][V_W-1] ? V_W'(-v12[1]) : V_W'(v12[1]);
    view_nxt.d      = V_W'(-v12[2]);
    view_nxt.behind = !v12[2][V_W-1];
  end

  assign vld  = v2_r;
  assign view = view_r;

endmodule

[rtl/wpsp_scale.sv]
// Projection scale: split partial products, then the numerator magnitude for the divide.
module wpsp_scale (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_vld,
  input  wpsp_pkg::view_t  view,
  input  wpsp_pkg::cfg_t   cfg,
  output logic             vld,
  output wpsp_pkg::num_t   num
);
  import wpsp_pkg::*;

  logic [PP_W-1:0] pxl_r, pxh_r, pyl_r, pyh_r;
  view_t           side_r;
  num_t            num_r, num_nxt;
  logic            v1_r, v2_r;
  logic [M_W-1:0]  mx, my;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_vld;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pxl_r  <= PP_W'(view.mag_x) * PP_W'(cfg.scale_x[SCH_W-1:0]);
      pxh_r  <= PP_W'(view.mag_x) * PP_W'(cfg.scale_x[SC_W-1:SCH_W]);
      pyl_r  <= PP_W'(view.mag_y) * PP_W'(cfg.scale_y[SCH_W-1:0]);
      pyh_r  <= PP_W'(view.mag_y) * PP_W'(cfg.scale_y[SC_W-1:SCH_W]);
      side_r <= view;
      num_r  <= num_nxt;
    end
  end

  always_comb begin
    mx = M_W'(pxl_r) + (M_W'(pxh_r) << SCH_W);
    my = M_W'(pyl_r) + (M_W'(pyh_r) << SCH_W);
    num_nxt.num_x  = {mx, 8'd0};
    num_nxt.num_y  = {my, 8'd0};
    num_nxt.neg_x  = side_r.neg_x;
    num_nxt.neg_y  = side_r.neg_y;
    num_nxt.d      = side_r.d;
    num_nxt.behind = side_r.behind;
  end

  assign vld = v2_r;
  assign num = num_r;

endmodule

[rtl/wpsp_div.sv]
// Pipelined restoring divider, one quotient bit per stage, x and y lanes share the divisor.
module wpsp_div (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_vld,
  input  wpsp_pkg::num_t    num,
  output logic              vld,
  output wpsp_pkg::div_st_t q
);
  import wpsp_pkg::*;

  div_st_t       st_r   [QW+1];
  div_st_t       st_nxt [QW+1];
  logic [QW:0]   v_r;
  logic          ox, oy;

  function automatic div_st_t step(input div_st_t s, input logic [QB_W-1:0] b);
    div_st_t        o;
    logic [V_W:0]   tx, ty;
    o  = s;
    tx = {s.rem_x, s.lo_x[b]};
    ty = {s.rem_y, s.lo_y[b]};
    if (tx >= {1'b0, s.d}) begin
      tx = tx - {1'b0, s.d};
      o.q_x[b] = 1'b1;
    end
    if (ty >= {1'b0, s.d}) begin
      ty = ty - {1'b0, s.d};
      o.q_y[b] = 1'b1;
    end
    o.rem_x = tx[V_W-1:0];
    o.rem_y = ty[V_W-1:0];
    return o;
  endfunction

  always_comb begin
    // quotient at or above 2^45 saturates anyway
    ox = V_W'(num.num_x[NUM_W-1:QW]) >= num.d;
    oy = V_W'(num.num_y[NUM_W-1:QW]) >= num.d;
    st_nxt[0].rem_x  = ox ? '0 : V_W'(num.num_x[NUM_W-1:QW]);
    st_nxt[0].rem_y  = oy ? '0 : V_W'(num.num_y[NUM_W-1:QW]);
    st_nxt[0].lo_x   = num.num_x[QW-1:0];
    st_nxt[0].lo_y   = num.num_y[QW-1:0];
    st_nxt[0].q_x    = '0;
    st_nxt[0].q_y    = '0;
    st_nxt[0].ovf_x  = ox;
    st_nxt[0].ovf_y  = oy;
    st_nxt[0].neg_x  = num.neg_x;
    st_nxt[0].neg_y  = num.neg_y;
    st_nxt[0].d      = num.d;
    st_nxt[0].behind = num.behind;
    for (int i = 1; i <= QW; i++) begin
      st_nxt[i] = step(st_r[i-1], QB_W'(QW - i));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[QW-1:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_r <= st_nxt;
    end
  end

  assign vld = v_r[QW];
  assign q   = st_r[QW];

endmodule

[rtl/wpsp_vp.sv]
// Viewport map: clamp and offset ndc, split viewport multiply, floor, saturate, sentinel.
module wpsp_vp (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_vld,
  input  wpsp_pkg::div_st_t q,
  input  wpsp_pkg::cfg_t    cfg,
  output logic              vld,
  output wpsp_pkg::scr_t    scr
);
  import wpsp_pkg::*;

  logic signed [NDC_W-1:0] ax_r, ay_r;
  logic                    b1_r, b2_r;
  logic [PL_W-1:0]         plx_r, ply_r;
  logic signed [PH_W-1:0]  phx_r, phy_r;
  scr_t                    scr_r, scr_nxt;
  logic                    v1_r, v2_r, v3_r;
  logic [QW-1:0]           qlx, qly;
  logic signed [NDC_W-1:0] nx, ny;
  logic signed [PF_W-1:0]  fx, fy;
  logic signed [SH_W-1:0]  shx, shy;

  function automatic logic signed [SCR_W-1:0] sat(input logic signed [SH_W-1:0] v);
    if (v > SAT_MAX) return SCR_W'(SAT_MAX);
    if (v < SAT_MIN) return SCR_W'(SAT_MIN);
    return SCR_W'(v);
  endfunction

  always_comb begin
    qlx = (q.ovf_x || q.q_x > NDC_LIM) ? NDC_LIM : q.q_x;
    qly = (q.ovf_y || q.q_y > NDC_LIM) ? NDC_LIM : q.q_y;
    nx  = q.neg_x ? -$signed({1'b0, qlx}) : $signed({1'b0, qlx});
    ny  = q.neg_y ? -$signed({1'b0, qly}) : $signed({1'b0, qly});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_vld;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ax_r  <= nx + NDC_ONE;
      ay_r  <= NDC_ONE - ny;
      b1_r  <= q.behind;
      plx_r <= PL_W'(ax_r[AL_W-1:0]) * PL_W'(cfg.vp_w);
      ply_r <= PL_W'(ay_r[AL_W-1:0]) * PL_W'(cfg.vp_h);
      phx_r <= $signed(ax_r[NDC_W-1:AL_W]) * $signed({1'b0, cfg.vp_w});
      phy_r <= $signed(ay_r[NDC_W-1:AL_W]) * $signed({1'b0, cfg.vp_h});
      b2_r  <= b1_r;
      scr_r <= scr_nxt;
    end
  end

  always_comb begin
    fx  = (PF_W'(phx_r) <<< AL_W) + $signed(PF_W'(plx_r));
    fy  = (PF_W'(phy_r) <<< AL_W) + $signed(PF_W'(ply_r));
    shx = fx[PF_W-1:13];
    shy = fy[PF_W-1:13];
    scr_nxt.behind = b2_r;
    scr_nxt.sx     = b2_r ? SENTINEL : sat(shx);
    scr_nxt.sy     = b2_r ? SENTINEL : sat(shy);
  end

  assign vld = v3_r;
  assign scr = scr_r;

endmodule
